[src/dnv_pkg.sv]
package dnv_pkg;

   localparam int DEFAULT_MAX_NAME_LENGTH  = 253;
   localparam int DEFAULT_MAX_LABEL_LENGTH = 63;

   localparam int NAME_BYTE_W  = 8;
   localparam int NAME_LEN_W   = 8;
   localparam int LABEL_CNT_W  = 2;

   localparam logic [LABEL_CNT_W-1:0] LABEL_COUNT_SAT = LABEL_CNT_W'(2);

   localparam logic [NAME_BYTE_W-1:0] CHAR_DOT    = 8'h2E;
   localparam logic [NAME_BYTE_W-1:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [NAME_BYTE_W-1:0] CHAR_STAR   = 8'h2A;

   typedef struct packed {
      logic is_plain;
      logic is_hyphen;
      logic is_dot;
      logic is_star;
   } char_class_type;

endpackage

[src/dnv_char_class.sv]
module dnv_char_class
   import dnv_pkg::*;
(
   input  logic [NAME_BYTE_W-1:0] name_byte,
   output char_class_type         char_class
);

   always_comb begin
      char_class.is_plain  = name_byte inside {[8'h61:8'h7A], [8'h41:8'h5A],
                                               [8'h30:8'h39], CHAR_HYPHEN};
      char_class.is_hyphen = (name_byte == CHAR_HYPHEN);
      char_class.is_dot    = (name_byte == CHAR_DOT);
      char_class.is_star   = (name_byte == CHAR_STAR);
   end

endmodule

[src/dns_name_validator.sv]
// DNS host-name validator with optional wildcard patterns.
// The request channel carries one byte of a name per beat; the beat with
// req_last_byte set closes the name. Exactly one response beat follows each
// name, carrying the verdict, the length without a trailing root dot and the
// wildcard flag. Bytes of a name that has already failed are still taken.
// The csr channel writes the pattern_allowed bit, which lets the first label
// be a lone asterisk; it is always ready and should be written between names.
// Each byte is registered in the input register on acceptance and processed
// there by the label and length logic; the verdict for a final byte is then
// registered in the response register, which presents it on rsp_valid.
// Unless a final byte waits, one byte is accepted per cycle, set by the single
// byte-processing stage between the input register and the response register.
// While a response waits on rsp_ready, non-final bytes keep flowing; a final
// byte is held in the input register until the response register frees.
// A synchronous reset empties both registers, clears all name state and
// clears pattern_allowed.
module dns_name_validator
   import dnv_pkg::*;
#(
   parameter int MAX_NAME_LENGTH  = DEFAULT_MAX_NAME_LENGTH,
   parameter int MAX_LABEL_LENGTH = DEFAULT_MAX_LABEL_LENGTH
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_pattern_allowed,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [NAME_BYTE_W-1:0] req_name_byte,
   input  logic                   req_last_byte,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_name_valid,
   output logic [NAME_LEN_W-1:0]  rsp_name_length,
   output logic                   rsp_has_wildcard
);

   localparam int LW = $clog2(MAX_LABEL_LENGTH + 2);
   localparam int TW = $clog2(MAX_NAME_LENGTH + 3);
   localparam logic [LW-1:0] LABEL_MAX = LW'(MAX_LABEL_LENGTH);
   localparam logic [TW-1:0] NAME_MAX  = TW'(MAX_NAME_LENGTH);
   localparam logic [TW-1:0] NAME_SAT  = TW'(MAX_NAME_LENGTH + 2);

   logic                   pattern_allowed_ff;

   logic                   s1_valid_ff;
   logic [NAME_BYTE_W-1:0] s1_byte_ff;
   logic                   s1_last_ff;

   logic [LW-1:0]          label_length_ff, label_length_in;
   logic [TW-1:0]          total_length_ff, total_length_in;
   logic [LABEL_CNT_W-1:0] label_count_ff, label_count_in;
   logic                   label_starts_star_ff, label_starts_star_in;
   logic                   last_was_hyphen_ff, last_was_hyphen_in;
   logic                   wildcard_seen_ff, wildcard_seen_in;
   logic                   error_seen_ff, error_seen_in;

   logic                   rsp_valid_ff;
   logic                   rsp_name_valid_ff, rsp_name_valid_in;
   logic [NAME_LEN_W-1:0]  rsp_name_length_ff, rsp_name_length_in;
   logic                   rsp_has_wildcard_ff, rsp_has_wildcard_in;

   char_class_type         char_class;
   logic [TW-1:0]          stripped;
   logic                   out_free;
   logic                   s1_fire;
   logic                   name_ok;

   dnv_char_class u_char_class (
      .name_byte  (s1_byte_ff),
      .char_class (char_class)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign csr_ready = 1'b1;

   always_comb begin
      label_length_in      = label_length_ff;
      label_count_in       = label_count_ff;
      label_starts_star_in = label_starts_star_ff;
      last_was_hyphen_in   = last_was_hyphen_ff;
      wildcard_seen_in     = wildcard_seen_ff;
      error_seen_in        = error_seen_ff;
      total_length_in      = (total_length_ff < NAME_SAT) ? total_length_ff + 1'b1
                                                          : total_length_ff;

      if (!char_class.is_dot) begin
         if (label_starts_star_ff) begin
            error_seen_in = 1'b1;
         end else if (char_class.is_plain) begin
            if (char_class.is_hyphen && label_length_ff == '0) begin
               error_seen_in = 1'b1;
            end
         end else if (char_class.is_star) begin
            if (!pattern_allowed_ff || label_length_ff != '0 || label_count_ff != '0) begin
               error_seen_in = 1'b1;
            end else begin
               label_starts_star_in = 1'b1;
            end
         end else begin
            error_seen_in = 1'b1;
         end
         last_was_hyphen_in = char_class.is_hyphen;
         if (label_length_ff <= LABEL_MAX) begin
            label_length_in = label_length_ff + 1'b1;
         end
      end

      if (char_class.is_dot || s1_last_ff) begin
         if (label_length_in == '0 || label_length_in > LABEL_MAX) begin
            error_seen_in = 1'b1;
         end else if (label_starts_star_in) begin
            wildcard_seen_in = 1'b1;
         end else if (last_was_hyphen_in) begin
            error_seen_in = 1'b1;
         end
         if (label_count_in < LABEL_COUNT_SAT) begin
            label_count_in = label_count_in + 1'b1;
         end
         label_length_in      = '0;
         label_starts_star_in = 1'b0;
         last_was_hyphen_in   = 1'b0;
      end

      stripped = total_length_in - TW'(char_class.is_dot);
      name_ok  = !error_seen_in && stripped != '0 && stripped <= NAME_MAX &&
                 (!wildcard_seen_in || label_count_in >= LABEL_COUNT_SAT);

      rsp_name_valid_in   = name_ok;
      rsp_name_length_in  = name_ok ? NAME_LEN_W'(stripped) : '0;
      rsp_has_wildcard_in = name_ok && wildcard_seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_allowed_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         pattern_allowed_ff <= csr_pattern_allowed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_name_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_fire && s1_last_ff)) begin
         label_length_ff      <= '0;
         total_length_ff      <= '0;
         label_count_ff       <= '0;
         label_starts_star_ff <= 1'b0;
         last_was_hyphen_ff   <= 1'b0;
         wildcard_seen_ff     <= 1'b0;
         error_seen_ff        <= 1'b0;
      end else if (s1_fire) begin
         label_length_ff      <= label_length_in;
         total_length_ff      <= total_length_in;
         label_count_ff       <= label_count_in;
         label_starts_star_ff <= label_starts_star_in;
         last_was_hyphen_ff   <= last_was_hyphen_in;
         wildcard_seen_ff     <= wildcard_seen_in;
         error_seen_ff        <= error_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         rsp_name_valid_ff   <= rsp_name_valid_in;
         rsp_name_length_ff  <= rsp_name_length_in;
         rsp_has_wildcard_ff <= rsp_has_wildcard_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_name_valid   = rsp_name_valid_ff;
   assign rsp_name_length  = rsp_name_length_ff;
   assign rsp_has_wildcard = rsp_has_wildcard_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("response beat appeared without a final byte");

   a_invalid_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_name_valid_ff |-> rsp_name_length_ff == '0 && !rsp_has_wildcard_ff)
      else $error("invalid verdict carries a length or wildcard flag");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> total_length_ff == '0 && label_count_ff == '0 &&
                                !error_seen_ff && !wildcard_seen_ff)
      else $error("name state not cleared after the final byte");

endmodule
